>>> src/stb_pkg.sv
package stb_pkg;

  localparam int unsigned NUM_TIMERS_DEF  = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned LOAD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DISABLED = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_EXPIRED  = 2'd2
  } status_e;

  // Controller to datapath strobes
  typedef struct packed {
    logic accept;    // request taken this cycle
    logic walk_clr;  // restart the tick walk at timer zero
    logic walk_rd;   // read the timer under the walk pointer
    logic res_load;  // capture a result
    logic res_tick;  // result comes from the flags after a tick walk
  } stb_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_last;
  } stb_sts_t;

endpackage

>>> src/stb_ram.sv
module stb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/stb_datapath.sv
module stb_datapath import stb_pkg::*; #(
  parameter int unsigned NUM_TIMERS  = NUM_TIMERS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stb_ctl_t            ctl_i,
  output stb_sts_t            sts_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [INDEX_W-1:0]  timer_index_i,
  input  logic [LOAD_W-1:0]   load_count_i,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned IdxW     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned ExtW     = IdxW + INDEX_W;
  localparam int unsigned LoadExtW = COUNT_WIDTH + LOAD_W;

  logic [NUM_TIMERS-1:0]  en_q, en_d;
  logic [NUM_TIMERS-1:0]  zero_q, zero_d;   // count is zero
  logic [IdxW-1:0]        addr, addr_q;
  logic                   idx_ok, idx_ok_q;
  logic [IdxW-1:0]        cnt_q, cnt_d;
  logic                   wb_vld_q, wb_vld_d;
  logic [IdxW-1:0]        wb_idx_q;
  logic [ExtW-1:0]        idx_ext;
  logic [LoadExtW-1:0]    load_ext;
  logic [COUNT_WIDTH-1:0] load_val;
  cmd_e                   cmd;
  logic [STATUS_W-1:0]    op_status, tick_status, status_q, status_d;

  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] cnt_dec;

  function automatic logic [STATUS_W-1:0] status_of(input logic en, input logic zero);
    if (!en) begin
      return ST_DISABLED;
    end else if (!zero) begin
      return ST_RUNNING;
    end
    return ST_EXPIRED;
  endfunction

  assign idx_ext  = {{IdxW{1'b0}}, timer_index_i};
  assign addr     = idx_ext[IdxW-1:0];
  assign idx_ok   = (idx_ext < ExtW'(NUM_TIMERS));
  assign load_ext = {{COUNT_WIDTH{1'b0}}, load_count_i};
  assign load_val = load_ext[COUNT_WIDTH-1:0];
  assign cmd      = cmd_e'(command_i);
  assign cnt_dec  = ram_rdata - COUNT_WIDTH'(1);

  // Status right after a start, stop or query
  always_comb begin
    case (cmd)
      CMD_START: op_status = idx_ok ? status_of(1'b1, load_val == '0) : ST_DISABLED;
      CMD_STOP:  op_status = ST_DISABLED;
      default:   op_status = idx_ok ? status_of(en_q[addr], zero_q[addr]) : ST_DISABLED;
    endcase
  end

  assign tick_status = idx_ok_q ? status_of(en_q[addr_q], zero_q[addr_q]) : ST_DISABLED;

  always_comb begin
    en_d      = en_q;
    zero_d    = zero_q;
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = load_val;
    if (ctl_i.accept && idx_ok) begin
      case (cmd)
        CMD_START: begin
          en_d[addr]   = 1'b1;
          zero_d[addr] = (load_val == '0);
          ram_we       = 1'b1;
        end
        CMD_STOP: begin
          en_d[addr]   = 1'b0;
          zero_d[addr] = 1'b0;
          ram_we       = 1'b1;
          ram_wdata    = '1;
        end
        default: ;
      endcase
    end
    // write back the decremented count in the cycle after its read
    if (wb_vld_q) begin
      ram_we           = 1'b1;
      ram_waddr        = wb_idx_q;
      ram_wdata        = cnt_dec;
      zero_d[wb_idx_q] = (cnt_dec == '0);
    end
  end

  // Only enabled, nonzero timers need a write back
  assign wb_vld_d = ctl_i.walk_rd && en_q[cnt_q] && !zero_q[cnt_q];

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.walk_clr) begin
      cnt_d = '0;
    end else if (ctl_i.walk_rd) begin
      cnt_d = cnt_q + IdxW'(1);
    end
  end

  assign sts_o.walk_last = (cnt_q == IdxW'(NUM_TIMERS - 1));

  assign status_d = ctl_i.res_load ? (ctl_i.res_tick ? tick_status : op_status) : status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= '0;
      zero_q   <= '1;
      cnt_q    <= '0;
      wb_vld_q <= 1'b0;
    end else begin
      en_q     <= en_d;
      zero_q   <= zero_d;
      cnt_q    <= cnt_d;
      wb_vld_q <= wb_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      addr_q   <= addr;
      idx_ok_q <= idx_ok;
    end
    wb_idx_q <= cnt_q;
    status_q <= status_d;
  end

  assign status_o = status_q;

  stb_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_TIMERS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctl_i.walk_rd),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

endmodule

>>> src/stb_ctrl.sv
module stb_ctrl import stb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CMD_W-1:0] command_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output stb_ctl_t         ctl_o,
  input  stb_sts_t         sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_RESULT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;
  logic   accept;
  logic   is_tick;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = (cmd_e'(command_i) == CMD_TICK);

  always_comb begin
    ctl_o.accept   = accept;
    ctl_o.walk_clr = accept && is_tick;
    ctl_o.walk_rd  = (state_q == S_WALK);
    ctl_o.res_tick = (state_q == S_RESULT);
    ctl_o.res_load = (accept && !is_tick) || ((state_q == S_RESULT) && slot_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && is_tick) state_q <= S_WALK;
        end
        S_WALK: begin
          if (sts_i.walk_last) state_q <= S_DRAIN;
        end
        // let the last write back land before reading the flags
        S_DRAIN: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (slot_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/software_timer_bank.sv
// Channel   Handshake                 Payload
// in        in_valid_i / in_ready_o   command_i, timer_index_i, load_count_i
// out       out_valid_o / out_ready_i status_o
//
// Start, stop and query results are registered at the edge that takes the request.
// A tick walks the count memory one timer per cycle, a rate set by the single read
// port of that memory, then registers its result from the flags after a drain state.
// Reset clears every enable flag and marks every count as zero; no clearing pass.
// A new request is taken only while no tick is in flight and the output register is
// free or being emptied in the same cycle.
module software_timer_bank import stb_pkg::*; #(
  parameter int unsigned NUM_TIMERS  = NUM_TIMERS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [INDEX_W-1:0]  timer_index_i,
  input  logic [LOAD_W-1:0]   load_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o
);

  stb_ctl_t ctl;
  stb_sts_t sts;

  stb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  stb_datapath #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (command_i),
    .timer_index_i (timer_index_i),
    .load_count_i  (load_count_i),
    .status_o      (status_o)
  );

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("request taken while a result is stuck");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_DISABLED || status_o == ST_RUNNING ||
                    status_o == ST_EXPIRED)
    else $error("status code out of range");

  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i != CMD_TICK |=> out_valid_o)
    else $error("missing result after start, stop or query");

  a_walk_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.walk_rd |-> !in_ready_o && !ctl.res_load)
    else $error("request or result during tick walk");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench import stb_pkg::*;;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 2 * (NUM_TIMERS_DEF + 3);
  localparam int unsigned PHASE_ITEMS = 483;

  // Tracks the timer bank and holds the statuses still owed by the block.
  class timer_scoreboard;
    logic                       enabled[NUM_TIMERS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] count[NUM_TIMERS_DEF];
    status_e                    status_q[$];
    int unsigned                mismatches;

    function new();
      foreach (enabled[i]) begin
        enabled[i] = 1'b0;
        count[i]   = '0;
      end
      mismatches = 0;
    endfunction

    function status_e timer_status(int unsigned idx);
      if (idx >= NUM_TIMERS_DEF || !enabled[idx]) return ST_DISABLED;
      return (count[idx] != '0) ? ST_RUNNING : ST_EXPIRED;
    endfunction

    function void note_request(cmd_e cmd, logic [INDEX_W-1:0] idx, logic [LOAD_W-1:0] load);
      case (cmd)
        CMD_START: if (int'(idx) < NUM_TIMERS_DEF) begin
          enabled[idx] = 1'b1;
          count[idx]   = COUNT_WIDTH_DEF'(load);
        end
        CMD_STOP: if (int'(idx) < NUM_TIMERS_DEF) begin
          enabled[idx] = 1'b0;
          count[idx]   = '1;
        end
        CMD_TICK: begin
          // zero counts hold, disabled timers hold
          foreach (count[i]) begin
            if (enabled[i] && count[i] != '0) count[i] = count[i] - 1'b1;
          end
        end
        default: ;
      endcase
      status_q.push_back(timer_status(int'(idx)));
    endfunction

    function void check_status(logic [STATUS_W-1:0] got);
      status_e want;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected status %0d with nothing pending", got);
        return;
      end
      want = status_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int unsigned outstanding();
      return status_q.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i     = '0;
  logic [INDEX_W-1:0]  timer_index_i = '0;
  logic [LOAD_W-1:0]   load_count_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [STATUS_W-1:0] status_o;

  timer_scoreboard sb = new();
  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 67;
  int unsigned idle_cycles = 0;

  software_timer_bank u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .timer_index_i (timer_index_i),
    .load_count_i  (load_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Called right after a rising edge; returns at the edge that takes the request.
  task automatic send_request(cmd_e cmd, logic [INDEX_W-1:0] idx, logic [LOAD_W-1:0] load);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    timer_index_i <= idx;
    load_count_i  <= load;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(cmd, idx, load);
  endtask

  // Hold off new requests until every pending status has come back.
  task automatic drain_statuses();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_status(status_o);
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    cmd_e                cmd;
    logic [INDEX_W-1:0]  idx;
    logic [LOAD_W-1:0]   load;
    int unsigned         pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, zero and full loads, expiry, stop and tick corners
    send_request(CMD_QUERY, 4'd0,  32'h0000_0000);
    send_request(CMD_TICK,  4'd15, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 4'd15, 32'h0000_0000);
    send_request(CMD_START, 4'd0,  32'h0000_0000);
    send_request(CMD_START, 4'd15, 32'hFFFF_FFFF);
    send_request(CMD_START, 4'd5,  32'h0000_0001);
    send_request(CMD_TICK,  4'd5,  32'h0000_0000);
    send_request(CMD_TICK,  4'd5,  32'hFFFF_FFFF);
    send_request(CMD_QUERY, 4'd0,  32'hFFFF_FFFF);
    send_request(CMD_TICK,  4'd15, 32'h0000_0000);
    send_request(CMD_STOP,  4'd15, 32'h0000_0000);
    send_request(CMD_TICK,  4'd15, 32'h0000_0000);
    send_request(CMD_START, 4'd15, 32'hFFFF_FFFF);
    send_request(CMD_START, 4'd3,  32'h0000_0002);
    send_request(CMD_STOP,  4'd3,  32'hFFFF_FFFF);
    send_request(CMD_QUERY, 4'd3,  32'h0000_0000);
    send_request(CMD_START, 4'd10, 32'hAAAA_AAAA);
    send_request(CMD_START, 4'd11, 32'h5555_5555);
    send_request(CMD_TICK,  4'd10, 32'h0000_0000);
    send_request(CMD_QUERY, 4'd11, 32'h0000_0000);
    send_request(CMD_STOP,  4'd0,  32'h0000_0000);
    send_request(CMD_QUERY, 4'd0,  32'h0000_0000);
    drain_statuses();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 6;  recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      cmd = CMD_START;
        else if (pick < 40) cmd = CMD_STOP;
        else if (pick < 68) cmd = CMD_QUERY;
        else                cmd = CMD_TICK;
        idx = INDEX_W'($urandom_range(0, NUM_TIMERS_DEF - 1));
        // half of the loads are short counts so that ticks reach expiry
        pick = $urandom_range(0, 3);
        if (pick < 2)       load = LOAD_W'($urandom_range(0, 6));
        else if (pick == 2) load = $urandom;
        else                load = 32'hFFFF_FFFF - LOAD_W'($urandom_range(0, 2));
        send_request(cmd, idx, load);
        if (n == PHASE_ITEMS / 2) drain_statuses();
      end
      drain_statuses();
    end

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
